@@ src/lrp_pkg.sv @@
package lrp_pkg;

  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH);
  localparam int unsigned TBL_ENTRIES = 4096;
  localparam int unsigned TBL_AW      = $clog2(TBL_ENTRIES);
  localparam int unsigned PROD_COUNT  = 1024;
  localparam int unsigned PROD_AW     = $clog2(PROD_COUNT);
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned N_W         = $clog2(MAX_RESULTS) + 1;
  localparam int unsigned HOP_LIMIT   = 64;
  localparam int unsigned HOP_W       = $clog2(HOP_LIMIT) + 1;

  typedef enum logic [2:0] {
    ACT_LD_CHECK  = 3'd0,
    ACT_LD_ACTION = 3'd1,
    ACT_LD_LENGTH = 3'd2,
    ACT_LD_LHS    = 3'd3,
    ACT_TOKEN     = 3'd4,
    ACT_RESTART   = 3'd5
  } lrp_act_e;

  typedef enum logic [2:0] {
    EV_SHIFT   = 3'd0,
    EV_REDUCE  = 3'd1,
    EV_ACCEPT  = 3'd2,
    EV_SYNTAX  = 3'd3,
    EV_ABORT   = 3'd4,
    EV_DISCARD = 3'd5
  } lrp_ev_e;

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_RECOVERY = 3'd1,
    CAUSE_EOF      = 3'd2,
    CAUSE_UNDER    = 3'd3,
    CAUSE_MISSING  = 3'd4
  } lrp_cause_e;

  typedef enum logic [2:0] {
    REG_START_STATE = 3'd0,
    REG_USED_SIZE   = 3'd1,
    REG_PARENT_SYM  = 3'd2,
    REG_DEFAULT_SYM = 3'd3,
    REG_ERROR_SYM   = 3'd4,
    REG_NO_ACTION   = 3'd5,
    REG_STOP_CODE   = 3'd6
  } lrp_reg_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [11:0]        table_index;
    logic signed [15:0] table_value;
    logic [14:0]        token;
    logic [31:0]        token_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [9:0]  production;
    logic [14:0] new_state;
    logic [31:0] reduced_value;
    logic [2:0]  abort_cause;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [14:0]        start_state;
    logic [12:0]        used_size;
    logic [14:0]        parent_symbol;
    logic [14:0]        default_symbol;
    logic [14:0]        error_symbol;
    logic signed [15:0] no_action_code;
    logic signed [15:0] stop_code;
  } cfg_t;

  typedef struct packed {
    logic              check_we;
    logic              action_we;
    logic [TBL_AW-1:0] addr;
    logic [15:0]       data;
  } tbl_wr_t;

  typedef struct packed {
    logic        start;
    logic [15:0] k;
    logic [16:0] sym;
  } lk_req_t;

  typedef struct packed {
    logic        done;
    logic        found;
    logic [15:0] act;
  } lk_rsp_t;

  function automatic logic in_table(logic [17:0] idx, logic [12:0] used);
    logic pos;
    pos = ~idx[17];
    return pos && (idx[16:0] < {4'b0, used}) && (idx[16:0] < 17'(TBL_ENTRIES));
  endfunction

  function automatic logic below_used(logic [15:0] act, logic [12:0] used);
    return $signed({act[15], act}) < $signed({4'b0, used});
  endfunction

endpackage

@@ src/lrp_lookup.sv @@
module lrp_lookup
  import lrp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  tbl_wr_t tw_i,
  input  lk_req_t req_i,
  output lk_rsp_t rsp_o
);

  typedef enum logic [4:0] {
    LK_IDLE = 5'b00001,
    LK_TRY  = 5'b00010,
    LK_TCMP = 5'b00100,
    LK_PAR  = 5'b01000,
    LK_PCMP = 5'b10000
  } lk_state_e;

  lk_state_e lk_q, lk_d;
  logic [15:0] k_q, k_d;
  logic [16:0] sym_q, sym_d;
  logic [HOP_W-1:0] hop_q, hop_d;
  logic done_q, done_d, found_q, found_d;
  logic [15:0] act_q, act_d;

  logic [15:0] check_mem [TBL_ENTRIES];
  logic [15:0] action_mem [TBL_ENTRIES];
  logic [15:0] check_rd, action_rd;
  logic rd_en;
  logic [TBL_AW-1:0] rd_addr;
  logic [17:0] idx;
  logic [16:0] par_sym;

  assign par_sym = {2'b0, cfg_i.parent_symbol};

  always_ff @(posedge clk_i) begin
    if (tw_i.check_we) begin
      check_mem[tw_i.addr] <= tw_i.data;
    end
    if (tw_i.action_we) begin
      action_mem[tw_i.addr] <= tw_i.data;
    end
    if (rd_en) begin
      check_rd  <= check_mem[rd_addr];
      action_rd <= action_mem[rd_addr];
    end
  end

  always_comb begin
    lk_d    = lk_q;
    k_d     = k_q;
    sym_d   = sym_q;
    hop_d   = hop_q;
    done_d  = 1'b0;
    found_d = found_q;
    act_d   = act_q;
    rd_en   = 1'b0;
    idx     = 18'({{2{k_q[15]}}, k_q}) + 18'({sym_q[16], sym_q});
    case (lk_q)
      LK_IDLE: begin
        if (req_i.start) begin
          k_d   = req_i.k;
          sym_d = req_i.sym;
          hop_d = '0;
          lk_d  = LK_TRY;
        end
      end
      LK_TRY: begin
        if (in_table(idx, cfg_i.used_size)) begin
          rd_en = 1'b1;
          lk_d  = LK_TCMP;
        end else begin
          lk_d = LK_PAR;
        end
      end
      LK_TCMP: begin
        if ({check_rd[15], check_rd} == sym_q) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          act_d   = action_rd;
          lk_d    = LK_IDLE;
        end else begin
          lk_d = LK_PAR;
        end
      end
      LK_PAR: begin
        idx = 18'({{2{k_q[15]}}, k_q}) + 18'(par_sym);
        if (in_table(idx, cfg_i.used_size)) begin
          rd_en = 1'b1;
          lk_d  = LK_PCMP;
        end else begin
          done_d  = 1'b1;
          found_d = 1'b0;
          lk_d    = LK_IDLE;
        end
      end
      LK_PCMP: begin
        if ({check_rd[15], check_rd} == par_sym && hop_q != HOP_W'(HOP_LIMIT)) begin
          hop_d = hop_q + 1'b1;
          k_d   = action_rd;
          lk_d  = LK_TRY;
        end else begin
          done_d  = 1'b1;
          found_d = 1'b0;
          lk_d    = LK_IDLE;
        end
      end
      default: lk_d = LK_IDLE;
    endcase
  end

  assign rd_addr = idx[TBL_AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_q   <= LK_IDLE;
      done_q <= 1'b0;
    end else begin
      lk_q   <= lk_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    sym_q   <= sym_d;
    hop_q   <= hop_d;
    found_q <= found_d;
    act_q   <= act_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.found = found_q;
  assign rsp_o.act   = act_q;

endmodule

@@ src/lrp_ctrl.sv @@
module lrp_ctrl
  import lrp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  output tbl_wr_t   tw_o,
  output lk_req_t   req_o,
  input  lk_rsp_t   rsp_i
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RDTOP = 13'b0000000000010,
    S_LKTOK = 13'b0000000000100,
    S_WTTOK = 13'b0000000001000,
    S_WTDEF = 13'b0000000010000,
    S_DEC   = 13'b0000000100000,
    S_RDLEN = 13'b0000001000000,
    S_LKLHS = 13'b0000010000000,
    S_WTLHS = 13'b0000100000000,
    S_RED   = 13'b0001000000000,
    S_ERLK  = 13'b0010000000000,
    S_ERWT  = 13'b0100000000000,
    S_EMIT  = 13'b1000000000000
  } ctrl_state_e;

  ctrl_state_e st_q, st_d;
  logic [SP_W-1:0] top_q, top_d, base_q, base_d, t_q, t_d;
  logic [15:0] bottom_q, bottom_d;
  logic [1:0] eflag_q, eflag_d;
  logic fin_q, fin_d, got_q, got_d, cont_q, cont_d;
  logic [N_W-1:0] n_q, n_d;
  logic [14:0] tok_q, tok_d;
  logic [VALUE_W-1:0] tv_q, tv_d;
  logic [15:0] s_q, s_d, act_q, act_d;
  logic [PROD_AW-1:0] pnum_q, pnum_d;
  out_item_t out_q, out_d;

  logic [15:0] state_mem [STACK_DEPTH];
  logic [VALUE_W-1:0] value_mem [STACK_DEPTH];
  logic [7:0] len_mem [PROD_COUNT];
  logic [15:0] lhs_mem [PROD_COUNT];

  logic st_re, st_we, val_re, val_we, p_re, len_we, lhs_we;
  logic [SP_W-1:0] st_ra, st_wa, val_ra, val_wa;
  logic [15:0] st_wd;
  logic [PROD_AW-1:0] p_ra;
  logic [15:0] st_rd, lhs_rd;
  logic st_zero_q;
  logic [15:0] s_rd;
  logic [VALUE_W-1:0] val_rd;
  logic [7:0] len_rd;
  logic accept;
  logic [16:0] diff;
  logic rsp_got;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      state_mem[st_wa] <= st_wd;
    end
    if (st_re) begin
      st_rd     <= state_mem[st_ra];
      st_zero_q <= (st_ra == '0);
    end
    if (val_we) begin
      value_mem[val_wa] <= tv_q;
    end
    if (val_re) begin
      val_rd <= value_mem[val_ra];
    end
    if (len_we) begin
      len_mem[in_data_i.table_index[PROD_AW-1:0]] <= in_data_i.table_value[7:0];
    end
    if (lhs_we) begin
      lhs_mem[in_data_i.table_index[PROD_AW-1:0]] <= in_data_i.table_value;
    end
    if (p_re) begin
      len_rd <= len_mem[p_ra];
      lhs_rd <= lhs_mem[p_ra];
    end
  end

  assign s_rd = st_zero_q ? bottom_q : st_rd;
  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == S_IDLE);
  assign out_valid_o = (st_q == S_EMIT);
  assign out_data_o = out_q;
  assign diff = {act_q[15], act_q} - {4'b0, cfg_i.used_size};
  assign rsp_got = rsp_i.found && (rsp_i.act != cfg_i.no_action_code);

  function automatic out_item_t mk_out(lrp_ev_e ev, logic [9:0] prod, logic [14:0] ns,
                                       logic [31:0] val, lrp_cause_e cause, logic last);
    out_item_t o;
    o.event_res     = ev;
    o.production    = prod;
    o.new_state     = ns;
    o.reduced_value = val;
    o.abort_cause   = cause;
    o.last          = last;
    return o;
  endfunction

  always_comb begin
    st_d     = st_q;
    top_d    = top_q;
    base_d   = base_q;
    t_d      = t_q;
    bottom_d = bottom_q;
    eflag_d  = eflag_q;
    fin_d    = fin_q;
    got_d    = got_q;
    cont_d   = cont_q;
    n_d      = n_q;
    tok_d    = tok_q;
    tv_d     = tv_q;
    s_d      = s_q;
    act_d    = act_q;
    pnum_d   = pnum_q;
    out_d    = out_q;
    st_re    = 1'b0;
    st_ra    = top_q;
    st_we    = 1'b0;
    st_wa    = top_q;
    st_wd    = act_q;
    val_re   = 1'b0;
    val_ra   = top_q;
    val_we   = 1'b0;
    val_wa   = top_q;
    p_re     = 1'b0;
    p_ra     = pnum_q;
    len_we   = 1'b0;
    lhs_we   = 1'b0;
    tw_o     = '0;
    req_o    = '0;
    tw_o.addr = in_data_i.table_index[TBL_AW-1:0];
    tw_o.data = in_data_i.table_value;

    case (st_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.action)
            ACT_LD_CHECK:  tw_o.check_we = 1'b1;
            ACT_LD_ACTION: tw_o.action_we = 1'b1;
            ACT_LD_LENGTH: len_we = (in_data_i.table_index < 12'(PROD_COUNT));
            ACT_LD_LHS:    lhs_we = (in_data_i.table_index < 12'(PROD_COUNT));
            ACT_TOKEN: begin
              if (!fin_q) begin
                tok_d = in_data_i.token;
                tv_d  = in_data_i.token_value;
                n_d   = '0;
                st_d  = S_RDTOP;
              end
            end
            ACT_RESTART: begin
              top_d    = '0;
              bottom_d = {1'b0, cfg_i.start_state};
              eflag_d  = '0;
              fin_d    = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_RDTOP: begin
        st_re = 1'b1;
        st_ra = top_q;
        st_d  = S_LKTOK;
      end
      S_LKTOK: begin
        s_d         = s_rd;
        req_o.start = 1'b1;
        req_o.k     = s_rd;
        req_o.sym   = {2'b0, tok_q};
        st_d        = S_WTTOK;
      end
      S_WTTOK: begin
        if (rsp_i.done) begin
          act_d = rsp_i.act;
          if (rsp_got) begin
            got_d = 1'b1;
            st_d  = S_DEC;
          end else begin
            req_o.start = 1'b1;
            req_o.k     = s_q;
            req_o.sym   = {2'b0, cfg_i.default_symbol};
            st_d        = S_WTDEF;
          end
        end
      end
      S_WTDEF: begin
        if (rsp_i.done) begin
          act_d = rsp_i.act;
          got_d = rsp_got;
          st_d  = S_DEC;
        end
      end
      S_DEC: begin
        cont_d = 1'b0;
        st_d   = S_EMIT;
        if (!got_q) begin
          if (eflag_q == 2'd3) begin
            if (tok_q == '0) begin
              fin_d = 1'b1;
              out_d = mk_out(EV_ABORT, '0, '0, '0, CAUSE_EOF, 1'b1);
            end else begin
              out_d = mk_out(EV_DISCARD, '0, s_q[14:0], '0, CAUSE_NONE, 1'b1);
            end
          end else if (n_q >= N_W'(MAX_RESULTS - 1)) begin
            fin_d = 1'b1;
            out_d = mk_out(EV_ABORT, '0, '0, '0, CAUSE_MISSING, 1'b1);
          end else begin
            eflag_d = 2'd3;
            t_d     = top_q;
            st_re   = 1'b1;
            st_ra   = top_q;
            st_d    = S_ERLK;
          end
        end else if (below_used(act_q, cfg_i.used_size)) begin
          if (act_q == cfg_i.stop_code) begin
            fin_d = 1'b1;
            out_d = mk_out(EV_ACCEPT, '0, s_q[14:0], '0, CAUSE_NONE, 1'b1);
          end else if ({1'b0, top_q} + 1'b1 >= (SP_W+1)'(STACK_DEPTH)) begin
            fin_d = 1'b1;
            out_d = mk_out(EV_ABORT, '0, '0, '0, CAUSE_MISSING, 1'b1);
          end else begin
            top_d  = top_q + 1'b1;
            st_we  = 1'b1;
            st_wa  = top_q + 1'b1;
            st_wd  = act_q;
            val_we = 1'b1;
            val_wa = top_q + 1'b1;
            if (eflag_q != '0) begin
              eflag_d = eflag_q - 1'b1;
            end
            out_d = mk_out(EV_SHIFT, '0, act_q[14:0], '0, CAUSE_NONE, 1'b1);
          end
        end else if (n_q >= N_W'(MAX_RESULTS - 1) || diff[16:PROD_AW] != '0) begin
          fin_d = 1'b1;
          out_d = mk_out(EV_ABORT, '0, '0, '0, CAUSE_MISSING, 1'b1);
        end else begin
          pnum_d = diff[PROD_AW-1:0];
          p_re   = 1'b1;
          p_ra   = diff[PROD_AW-1:0];
          st_d   = S_RDLEN;
        end
      end
      S_RDLEN: begin
        if (len_rd > {1'b0, top_q}) begin
          fin_d  = 1'b1;
          cont_d = 1'b0;
          out_d  = mk_out(EV_ABORT, '0, '0, '0, CAUSE_UNDER, 1'b1);
          st_d   = S_EMIT;
        end else begin
          base_d = top_q - len_rd[SP_W-1:0];
          st_re  = 1'b1;
          st_ra  = top_q - len_rd[SP_W-1:0];
          st_d   = S_LKLHS;
        end
      end
      S_LKLHS: begin
        req_o.start = 1'b1;
        req_o.k     = s_rd;
        req_o.sym   = {lhs_rd[15], lhs_rd};
        st_d        = S_WTLHS;
      end
      S_WTLHS: begin
        if (rsp_i.done) begin
          if (!rsp_i.found || base_q == {SP_W{1'b1}}) begin
            fin_d  = 1'b1;
            cont_d = 1'b0;
            out_d  = mk_out(EV_ABORT, '0, '0, '0, CAUSE_MISSING, 1'b1);
            st_d   = S_EMIT;
          end else begin
            top_d  = base_q + 1'b1;
            st_we  = 1'b1;
            st_wa  = base_q + 1'b1;
            st_wd  = rsp_i.act;
            act_d  = rsp_i.act;
            val_re = 1'b1;
            val_ra = base_q + 1'b1;
            st_d   = S_RED;
          end
        end
      end
      S_RED: begin
        out_d  = mk_out(EV_REDUCE, pnum_q, act_q[14:0], val_rd, CAUSE_NONE, 1'b0);
        n_d    = n_q + 1'b1;
        cont_d = 1'b1;
        st_d   = S_EMIT;
      end
      S_ERLK: begin
        req_o.start = 1'b1;
        req_o.k     = s_rd;
        req_o.sym   = {2'b0, cfg_i.error_symbol};
        st_d        = S_ERWT;
      end
      S_ERWT: begin
        if (rsp_i.done) begin
          if (rsp_i.found && below_used(rsp_i.act, cfg_i.used_size)) begin
            if (t_q == {SP_W{1'b1}}) begin
              top_d  = t_q;
              fin_d  = 1'b1;
              cont_d = 1'b0;
              out_d  = mk_out(EV_ABORT, '0, '0, '0, CAUSE_MISSING, 1'b1);
            end else begin
              top_d  = t_q + 1'b1;
              st_we  = 1'b1;
              st_wa  = t_q + 1'b1;
              st_wd  = rsp_i.act;
              n_d    = n_q + 1'b1;
              cont_d = 1'b1;
              out_d  = mk_out(EV_SYNTAX, '0, rsp_i.act[14:0], '0, CAUSE_NONE, 1'b0);
            end
            st_d = S_EMIT;
          end else if (t_q == '0) begin
            top_d  = '0;
            fin_d  = 1'b1;
            cont_d = 1'b0;
            out_d  = mk_out(EV_ABORT, '0, '0, '0, CAUSE_RECOVERY, 1'b1);
            st_d   = S_EMIT;
          end else begin
            t_d   = t_q - 1'b1;
            st_re = 1'b1;
            st_ra = t_q - 1'b1;
            st_d  = S_ERLK;
          end
        end
      end
      S_EMIT: begin
        if (out_ready_i) begin
          st_d = cont_q ? S_RDTOP : S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      top_q    <= '0;
      bottom_q <= '0;
      eflag_q  <= '0;
      fin_q    <= 1'b0;
      cont_q   <= 1'b0;
      n_q      <= '0;
    end else begin
      st_q     <= st_d;
      top_q    <= top_d;
      bottom_q <= bottom_d;
      eflag_q  <= eflag_d;
      fin_q    <= fin_d;
      cont_q   <= cont_d;
      n_q      <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    t_q    <= t_d;
    got_q  <= got_d;
    tok_q  <= tok_d;
    tv_q   <= tv_d;
    s_q    <= s_d;
    act_q  <= act_d;
    pnum_q <= pnum_d;
    out_q  <= out_d;
  end

endmodule

@@ src/lr_parse_table_engine.sv @@
// Load and restart beats are acted on in the idle state as they are accepted. A token
// beat runs table probes: each probe is one read of the check/action memories in the
// shared lookup unit, each parent hop adds two probes, and each reduction adds a
// length/lhs read, a stack read and one lookup. Results leave one at a time.
// Reset clears config registers, stack pointer, error flag and finished flag;
// the stack bottom reads as state 0 until a restart beat. Tables are not cleared.
module lr_parse_table_engine
  import lrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  cfg_t    cfg_q;
  tbl_wr_t tw;
  lk_req_t req;
  lk_rsp_t rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_START_STATE: cfg_q.start_state    <= cfg_data_i[14:0];
        REG_USED_SIZE:   cfg_q.used_size      <= cfg_data_i[12:0];
        REG_PARENT_SYM:  cfg_q.parent_symbol  <= cfg_data_i[14:0];
        REG_DEFAULT_SYM: cfg_q.default_symbol <= cfg_data_i[14:0];
        REG_ERROR_SYM:   cfg_q.error_symbol   <= cfg_data_i[14:0];
        REG_NO_ACTION:   cfg_q.no_action_code <= cfg_data_i;
        REG_STOP_CODE:   cfg_q.stop_code      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lrp_lookup u_lookup (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .tw_i   (tw),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  lrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .tw_o        (tw),
    .req_o       (req),
    .rsp_i       (rsp)
  );

endmodule
